/* rtl/mcpg_pkg.sv */
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared widths, request codes and the job word passed from the walk front
// end to the point emitter.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int OFS_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int PT_BITS    = COORD_BITS + 2;
  localparam int SUM_BITS   = DEC_BITS + 1;
  localparam int BRUSH_BITS = 8;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam int PTS_PER_STEP = 8;
  localparam int IDX_BITS     = $clog2(PTS_PER_STEP);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic                         done;
    logic [COORD_BITS-1:0]        cx;
    logic [COORD_BITS-1:0]        cy;
    logic signed [OFS_BITS-1:0]   x;
    logic signed [OFS_BITS-1:0]   y;
    logic [BRUSH_BITS-1:0]        brush;
  } job_t;

endpackage

/* rtl/mcpg_front.sv */
// ----------------------------------------------------------------------------
// mcpg_front
// Takes start and step words, holds the circle walk state and turns each
// step into a job word for the emitter.
// ----------------------------------------------------------------------------
module mcpg_front
  import mcpg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   req_type,
  input  logic [COORD_BITS-1:0]  ctr_x,
  input  logic [COORD_BITS-1:0]  ctr_y,
  input  logic [COORD_BITS-1:0]  radius,
  input  logic [BRUSH_BITS-1:0]  thickness,
  output logic                   job_push,
  output job_t                   job
);

  logic signed [OFS_BITS-1:0] offset_x, offset_y;
  logic signed [DEC_BITS-1:0] decision;
  logic [COORD_BITS-1:0]      center_col, center_row;
  logic [BRUSH_BITS-1:0]      brush;

  logic signed [OFS_BITS-1:0] offset_x_next, offset_y_next;
  logic signed [DEC_BITS-1:0] decision_next;
  logic signed [DEC_BITS-1:0] xe, ye;
  logic signed [SUM_BITS-1:0] dsum;
  logic                       finished;
  logic [BRUSH_BITS-1:0]      brush_calc;

  assign finished = offset_y < offset_x;
  assign xe   = DEC_BITS'(offset_x);
  assign ye   = DEC_BITS'(offset_y);
  assign dsum = SUM_BITS'(decision) + SUM_BITS'(offset_y);

  always_comb begin
    if (decision < 0 && dsum <= 0) begin
      offset_x_next = offset_x + OFS_BITS'(1);
      offset_y_next = offset_y;
      decision_next = decision + (xe <<< 1) + DEC_BITS'(3);
    end else if (decision > 0 && dsum > 0) begin
      offset_x_next = offset_x;
      offset_y_next = offset_y - OFS_BITS'(1);
      decision_next = decision - (ye <<< 1) + DEC_BITS'(1);
    end else begin
      offset_x_next = offset_x + OFS_BITS'(1);
      offset_y_next = offset_y - OFS_BITS'(1);
      decision_next = decision + ((xe - ye) <<< 1) + DEC_BITS'(4);
    end
  end

  always_comb begin
    if (!thickness[0]) begin
      brush_calc = thickness >> 1;
    end else if (thickness == BRUSH_BITS'(1)) begin
      brush_calc = '0;
    end else begin
      brush_calc = (thickness >> 1) + BRUSH_BITS'(1);
    end
  end

  assign job_push   = accept && (req_type == REQ_STEP);
  assign job.done   = finished;
  assign job.cx     = center_col;
  assign job.cy     = center_row;
  assign job.x      = offset_x;
  assign job.y      = offset_y;
  assign job.brush  = brush;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x   <= '0;
      offset_y   <= '0;
      decision   <= '0;
      center_col <= '0;
      center_row <= '0;
      brush      <= '0;
    end else if (accept) begin
      if (req_type == REQ_START) begin
        center_col <= ctr_x;
        center_row <= ctr_y;
        offset_x   <= '0;
        offset_y   <= OFS_BITS'(radius);
        decision   <= DEC_BITS'(1) - {{(DEC_BITS-COORD_BITS-1){1'b0}}, radius, 1'b0};
        brush      <= brush_calc;
      end else if (!finished) begin
        offset_x <= offset_x_next;
        offset_y <= offset_y_next;
        decision <= decision_next;
      end
    end
  end

endmodule

/* rtl/mcpg_queue.sv */
// ----------------------------------------------------------------------------
// mcpg_queue
// Short job queue between the walk front end and the point emitter.
// ----------------------------------------------------------------------------
module mcpg_queue
  import mcpg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  job_t  wr_job,
  input  logic  rd,
  output job_t  rd_job,
  output logic  q_full,
  output logic  q_empty
);

  job_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QCNT_BITS-1:0] count;

  assign q_full  = count == QCNT_BITS'(QDEPTH);
  assign q_empty = count == '0;
  assign rd_job  = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QPTR_BITS'(1);
      end
      if (rd) begin
        rptr <= rptr + QPTR_BITS'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/mcpg_back.sv */
// ----------------------------------------------------------------------------
// mcpg_back
// Point emitter: walks the eight octant points of the head job, or gives one
// done word, into the output register.
// ----------------------------------------------------------------------------
module mcpg_back
  import mcpg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  job_t                      head,
  output logic                      q_rd,
  input  logic                      pop,
  output logic                      empty,
  output logic signed [PT_BITS-1:0] point_x,
  output logic signed [PT_BITS-1:0] point_y,
  output logic [BRUSH_BITS-1:0]     brush_radius,
  output logic                      point_valid,
  output logic                      done_res,
  output logic                      last
);

  logic                      out_valid;
  logic [IDX_BITS-1:0]       idx;
  logic                      load;
  logic                      idx_last;
  logic signed [PT_BITS-1:0] ca, cb, oa, ob, px, py;

  assign empty    = !out_valid;
  assign load     = !q_empty && (!out_valid || pop);
  assign idx_last = idx == IDX_BITS'(PTS_PER_STEP - 1);
  assign q_rd     = load && (head.done || idx_last);

  // idx[2] swaps x/y offsets, idx[1] negates column offset, idx[0] row offset
  always_comb begin
    ca = PT_BITS'({1'b0, head.cx});
    cb = PT_BITS'({1'b0, head.cy});
    oa = idx[2] ? PT_BITS'(head.y) : PT_BITS'(head.x);
    ob = idx[2] ? PT_BITS'(head.x) : PT_BITS'(head.y);
    px = idx[1] ? ca - oa : ca + oa;
    py = idx[0] ? cb - ob : cb + ob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= q_rd ? '0 : idx + IDX_BITS'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.done) begin
        point_x      <= '0;
        point_y      <= '0;
        brush_radius <= '0;
        point_valid  <= 1'b0;
        done_res     <= 1'b1;
        last         <= 1'b1;
      end else begin
        point_x      <= px;
        point_y      <= py;
        brush_radius <= head.brush;
        point_valid  <= 1'b1;
        done_res     <= 1'b0;
        last         <= idx_last;
      end
    end
  end

endmodule

/* rtl/midpoint_circle_point_generator.sv */
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator
// Midpoint circle walk: start words load geometry, step words give eight
// symmetric brush centers or one done word.
// ----------------------------------------------------------------------------
//   channel   handshake        fields
//   request   push / full      req_type ctr_x ctr_y radius thickness
//   result    pop / empty      point_x point_y brush_radius point_valid
//                              done_res last
//
// A step word gives eight results, one per point, or one done word once the
// circle is done; start words give no result. The emitter's output register
// gives one point per cycle while results are popped; a 4-deep job queue lets
// requests keep flowing while results stall. Reset clears walk state to zero.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator
  import mcpg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      req_type,
  input  logic [COORD_BITS-1:0]     ctr_x,
  input  logic [COORD_BITS-1:0]     ctr_y,
  input  logic [COORD_BITS-1:0]     radius,
  input  logic [BRUSH_BITS-1:0]     thickness,
  input  logic                      pop,
  output logic                      empty,
  output logic signed [PT_BITS-1:0] point_x,
  output logic signed [PT_BITS-1:0] point_y,
  output logic [BRUSH_BITS-1:0]     brush_radius,
  output logic                      point_valid,
  output logic                      done_res,
  output logic                      last
);

  logic accept;
  logic job_push;
  job_t job_in, job_head;
  logic q_rd, q_full, q_empty;

  assign full   = q_full;
  assign accept = push && !q_full;

  mcpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .ctr_x     (ctr_x),
    .ctr_y     (ctr_y),
    .radius    (radius),
    .thickness (thickness),
    .job_push  (job_push),
    .job       (job_in)
  );

  mcpg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_job  (job_in),
    .rd      (q_rd),
    .rd_job  (job_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  mcpg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (job_head),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .point_x      (point_x),
    .point_y      (point_y),
    .brush_radius (brush_radius),
    .point_valid  (point_valid),
    .done_res     (done_res),
    .last         (last)
  );

`ifndef ASSERT_OFF
  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("job queue read while empty");

  a_done_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !point_valid) |-> (done_res && last))
    else $error("done word without done/last marks");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("result or full flag set after reset");

  a_start_no_job: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_START) |-> !job_push)
    else $error("start word queued a job");
`endif

endmodule
